/* sv/mkfc_pkg.sv */
package mkfc_pkg;

    // Kinds of beat on the command port.
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_BUS_READ  = 2'd0;
    localparam t_mode MODE_BUS_WRITE = 2'd1;
    localparam t_mode MODE_KEY       = 2'd2;
    localparam t_mode MODE_TICK      = 2'd3;

    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;
    localparam int KEY_W  = 8;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [KEY_W-1:0]  t_key;

    // Fixed device addresses that do not move with the parameters.
    localparam t_addr CONSOLE_ADDR = 32'hFFF0_0000;
    localparam t_addr CONTROL_ADDR = 32'hFFF0_0004;

    // Requests from the decoder to the key FIFO.
    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    // Status from the key FIFO back to the decoder.
    typedef struct packed {
        logic has_data;
        logic full;
    } t_fifo_sts;

endpackage

/* sv/mmio_keyboard_fifo_console_device.sv */
// Memory-mapped keyboard, timer, console and control device. A beat is
// offered by raising start with i_mode and its payload; it is taken at any
// rising edge where start is high and busy is low, and busy is never raised,
// so one beat can be taken in every cycle. Every beat gives exactly one
// result, shown on the o_ ports with o_valid high for one cycle in the
// cycle after the beat was taken. The receiver cannot stall, so results must
// be captured when o_valid is high. A popped key comes from the key FIFO
// memory, whose read data is registered. Reads at the data address pop one
// byte, sign-extended, or return zero when nothing is waiting; the status
// address returns one while bytes are waiting; the timer address reads and
// loads the tick counter. A write to the console address emits its low
// byte, and a write of zero to the control address raises o_halt_request.
// Keys that arrive while the FIFO holds FIFO_DEPTH-1 bytes are dropped.
// Unknown addresses read as zero and ignore writes.
module mmio_keyboard_fifo_console_device
    import mkfc_pkg::*;
#(
    parameter int          FIFO_DEPTH         = 256,
    parameter logic [31:0] TIMER_ADDRESS      = 32'hFFF0_0008,
    parameter logic [31:0] KEY_DATA_ADDRESS   = 32'hFFF0_000C,
    parameter logic [31:0] KEY_STATUS_ADDRESS = 32'hFFF0_0010
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_mode i_mode,
    input  t_addr i_address,
    input  t_data i_write_data,
    input  t_key  i_key_byte,
    output logic  o_valid,
    output t_data o_read_data,
    output logic  o_console_valid,
    output t_key  o_console_byte,
    output logic  o_halt_request
);

    logic      accept;
    t_fifo_ctl fifo_ctl;
    t_fifo_sts fifo_sts;
    t_key      fifo_q;

    logic      is_read;
    logic      is_write;
    logic      rd_timer;
    logic      rd_data;
    logic      rd_status;
    logic      wr_timer;
    logic      wr_console;
    logic      wr_control;

    t_data     r_tick;
    t_data     n_tick;
    logic      r_valid;
    logic      r_pop;
    t_data     r_word;
    t_data     n_word;
    logic      r_console_valid;
    t_key      r_console_byte;
    logic      r_halt;

    // Nothing ever holds the port off; every cycle can take a beat.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Address decode. The priority follows the register map: on a read the
    // timer wins over the key data and then the key status; on a write the
    // timer wins over the console and then the control register.
    assign is_read    = accept && (i_mode == MODE_BUS_READ);
    assign is_write   = accept && (i_mode == MODE_BUS_WRITE);
    assign rd_timer   = is_read && (i_address == TIMER_ADDRESS);
    assign rd_data    = is_read && !rd_timer && (i_address == KEY_DATA_ADDRESS);
    assign rd_status  = is_read && !rd_timer && !rd_data
                        && (i_address == KEY_STATUS_ADDRESS);
    assign wr_timer   = is_write && (i_address == TIMER_ADDRESS);
    assign wr_console = is_write && !wr_timer && (i_address == CONSOLE_ADDR);
    assign wr_control = is_write && !wr_timer && !wr_console
                        && (i_address == CONTROL_ADDR);

    assign fifo_ctl.push = accept && (i_mode == MODE_KEY);
    assign fifo_ctl.pop  = rd_data;

    mkfc_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fifo_ctl),
        .i_key   (i_key_byte),
        .o_sts   (fifo_sts),
        .o_q     (fifo_q)
    );

    // The tick counter wraps naturally at the top of its range.
    always_comb begin
        n_tick = r_tick;
        if (wr_timer) begin
            n_tick = i_write_data;
        end else if (accept && (i_mode == MODE_TICK)) begin
            n_tick = r_tick + 1'b1;
        end
    end

    // Read word for everything except a key pop, whose byte comes instead from
    // the registered read data of the FIFO memory.
    always_comb begin
        n_word = '0;
        if (rd_timer) begin
            n_word = r_tick;
        end else if (rd_status) begin
            n_word = {{(DATA_W-1){1'b0}}, fifo_sts.has_data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick          <= '0;
            r_valid         <= 1'b0;
            r_pop           <= 1'b0;
            r_console_valid <= 1'b0;
            r_halt          <= 1'b0;
        end else begin
            r_tick          <= n_tick;
            r_valid         <= accept;
            r_pop           <= rd_data && fifo_sts.has_data;
            r_console_valid <= wr_console;
            r_halt          <= wr_control && (i_write_data == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_word         <= n_word;
        r_console_byte <= wr_console ? i_write_data[KEY_W-1:0] : '0;
    end

    assign o_valid         = r_valid;
    assign o_read_data     = r_pop ? {{(DATA_W-KEY_W){fifo_q[KEY_W-1]}}, fifo_q}
                                   : r_word;
    assign o_console_valid = r_console_valid;
    assign o_console_byte  = r_console_byte;
    assign o_halt_request  = r_halt;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("a taken beat gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_valid)
        else $error("a result appeared without a taken beat");

    a_console_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_console_valid || o_halt_request || r_pop) |-> o_valid)
        else $error("a side effect was reported outside a result");

    a_console_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_console_valid |-> (o_console_byte == '0))
        else $error("console byte is not zero without a console write");

endmodule

/* sv/mkfc_fifo.sv */
module mkfc_fifo
    import mkfc_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_fifo_ctl i_ctl,
    input  t_key      i_key,
    output t_fifo_sts o_sts,
    output t_key      o_q
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FIFO_DEPTH - 1);

    t_key             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_next;
    t_key             r_q;
    logic             do_push;
    logic             do_pop;

    assign wr_next = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;

    // One slot is always left free, so full is seen one step ahead.
    assign o_sts.has_data = (r_wr_ptr != r_rd_ptr);
    assign o_sts.full     = (wr_next == r_rd_ptr);

    assign do_push = i_ctl.push && !o_sts.full;
    assign do_pop  = i_ctl.pop && o_sts.has_data;

    always_comb begin
        n_wr_ptr = do_push ? wr_next : r_wr_ptr;
        n_rd_ptr = do_pop  ? rd_next : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // The oldest byte is read every cycle; the caller keeps it only on a pop.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_key;
        end
        r_q <= mem[r_rd_ptr];
    end

    assign o_q = r_q;

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr <= LAST_IDX)
        else $error("write pointer beyond the FIFO depth");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_ptr <= LAST_IDX)
        else $error("read pointer beyond the FIFO depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sts.full && !i_ctl.pop) |=> $stable(r_wr_ptr))
        else $error("write pointer moved while the FIFO was full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sts.has_data |=> $stable(r_rd_ptr))
        else $error("read pointer moved while the FIFO was empty");

endmodule

/* sim/mmio_keyboard_fifo_console_device_tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for the keyboard, timer, console and control device.
// An initial block builds the whole list of beats up front. A clocked driver
// offers them one at a time on the command port, and a clocked monitor checks
// every result strobe against a queue of predicted responses. The bench keeps
// its own model of the key FIFO, the tick counter and the address decoder.
module mmio_keyboard_fifo_console_device_tb
    import mkfc_pkg::*;
();

    // The device is built with its default map, repeated here so that the
    // bench can aim beats at each register.
    localparam int    KEY_DEPTH     = 256;
    localparam t_addr TICK_REG_ADDR = 32'hFFF0_0008;
    localparam t_addr KEY_DATA_ADDR = 32'hFFF0_000C;
    localparam t_addr KEY_STAT_ADDR = 32'hFFF0_0010;

    localparam int BEAT_TARGET = 1750;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_LIMIT = 100;

    // One command beat, together with the chance in a hundred that the driver
    // leaves the port idle instead of offering it, each time it could offer it.
    typedef struct {
        t_mode       mode;
        t_addr       addr;
        t_data       wdata;
        t_key        key;
        int unsigned gap_pct;
    } t_beat;

    // What the device should show on its result ports for one beat.
    typedef struct {
        t_data read_data;
        logic  console_valid;
        t_key  console_byte;
        logic  halt_request;
    } t_response;

    logic  i_clk        = 1'b0;
    logic  i_rst_n      = 1'b0;
    logic  start        = 1'b0;
    t_mode i_mode       = MODE_TICK;
    t_addr i_address    = '0;
    t_data i_write_data = '0;
    t_key  i_key_byte   = '0;

    logic  busy;
    logic  o_valid;
    t_data o_read_data;
    logic  o_console_valid;
    t_key  o_console_byte;
    logic  o_halt_request;

    mmio_keyboard_fifo_console_device #(
        .FIFO_DEPTH         (KEY_DEPTH),
        .TIMER_ADDRESS      (TICK_REG_ADDR),
        .KEY_DATA_ADDRESS   (KEY_DATA_ADDR),
        .KEY_STATUS_ADDRESS (KEY_STAT_ADDR)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .i_key_byte      (i_key_byte),
        .o_valid         (o_valid),
        .o_read_data     (o_read_data),
        .o_console_valid (o_console_valid),
        .o_console_byte  (o_console_byte),
        .o_halt_request  (o_halt_request)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Beats waiting to be offered, and responses waiting to be seen.
    t_beat     pending_q[$];
    t_response expected_q[$];
    t_beat     cur_beat;

    // The bench's own copy of the device state. The key store is only ever
    // read at entries that have been written.
    t_key        key_mem [KEY_DEPTH];
    int unsigned key_wr_idx = 0;
    int unsigned key_rd_idx = 0;
    t_data       tick_count = '0;

    // Bookkeeping for the closing summary and the verdict.
    int unsigned fault_count   = 0;
    int unsigned beats_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned peak_fill     = 0;
    int unsigned keys_dropped  = 0;
    int unsigned keys_popped   = 0;
    int unsigned empty_reads   = 0;
    int unsigned timer_wraps   = 0;
    int unsigned console_bytes = 0;
    int unsigned halts_seen    = 0;
    int unsigned phase_gap     = 0;

    // Works out the response to one beat and moves the model state on. The
    // decode order mirrors the device: a read checks the timer, then the key
    // data, then the key status; a write checks the timer, then the console,
    // then the control register.
    function automatic t_response predict_response(input t_beat b);
        t_response   r;
        int unsigned next_wr;
        int unsigned fill;
        r = '{read_data: '0, console_valid: 1'b0, console_byte: '0, halt_request: 1'b0};
        case (b.mode)
            MODE_BUS_READ: begin
                if (b.addr == TICK_REG_ADDR) begin
                    r.read_data = tick_count;
                end else if (b.addr == KEY_DATA_ADDR) begin
                    if (key_wr_idx != key_rd_idx) begin
                        r.read_data = {{(DATA_W-KEY_W){key_mem[key_rd_idx][KEY_W-1]}},
                                       key_mem[key_rd_idx]};
                        key_rd_idx  = (key_rd_idx + 1) % KEY_DEPTH;
                        keys_popped++;
                    end else begin
                        empty_reads++;
                    end
                end else if (b.addr == KEY_STAT_ADDR) begin
                    r.read_data = (key_wr_idx != key_rd_idx) ? 32'd1 : 32'd0;
                end
            end
            MODE_BUS_WRITE: begin
                if (b.addr == TICK_REG_ADDR) begin
                    tick_count = b.wdata;
                end else if (b.addr == CONSOLE_ADDR) begin
                    r.console_valid = 1'b1;
                    r.console_byte  = b.wdata[KEY_W-1:0];
                    console_bytes++;
                end else if (b.addr == CONTROL_ADDR && b.wdata == '0) begin
                    r.halt_request = 1'b1;
                    halts_seen++;
                end
            end
            MODE_KEY: begin
                // One slot is always left empty, so a full FIFO holds one key
                // fewer than its depth and further keys are thrown away.
                next_wr = (key_wr_idx + 1) % KEY_DEPTH;
                if (next_wr != key_rd_idx) begin
                    key_mem[key_wr_idx] = b.key;
                    key_wr_idx          = next_wr;
                end else begin
                    keys_dropped++;
                end
            end
            default: begin
                if (tick_count == '1)
                    timer_wraps++;
                tick_count = tick_count + 1'b1;
            end
        endcase
        fill = (key_wr_idx + KEY_DEPTH - key_rd_idx) % KEY_DEPTH;
        if (fill > peak_fill)
            peak_fill = fill;
        return r;
    endfunction

    // Driver. A beat is taken at an edge where start is high and busy is low;
    // its response is predicted there and then. Once the port is free, the
    // next beat is offered unless the phase calls for an idle cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_q.push_back(predict_response(cur_beat));
                beats_taken++;
            end
            if (!start || !busy) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= pending_q[0].gap_pct) begin
                    cur_beat = pending_q.pop_front();
                    start        <= 1'b1;
                    i_mode       <= cur_beat.mode;
                    i_address    <= cur_beat.addr;
                    i_write_data <= cur_beat.wdata;
                    i_key_byte   <= cur_beat.key;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string field, input t_data want, input t_data got);
        if (got !== want)
            report_fault($sformatf("result %0d %s expected %h got %h",
                                   results_seen, field, want, got));
    endtask

    // Monitor. The receiver cannot hold results off, so every strobe is
    // consumed at the edge that ends it.
    always @(posedge i_clk) begin
        t_response want;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                report_fault($sformatf("result with nothing expected, read data %h",
                                       o_read_data));
            end else begin
                want = expected_q.pop_front();
                check_field("read_data", want.read_data, o_read_data);
                check_field("console_valid", 32'(want.console_valid), 32'(o_console_valid));
                check_field("console_byte", 32'(want.console_byte), 32'(o_console_byte));
                check_field("halt_request", 32'(want.halt_request), 32'(o_halt_request));
            end
            results_seen++;
        end
    end

    task automatic add_beat(input t_mode mode, input t_addr addr, input t_data wdata,
                            input t_key key);
        pending_q.push_back('{mode: mode, addr: addr, wdata: wdata, key: key,
                              gap_pct: phase_gap});
    endtask

    // Mostly one of the decoded registers, sometimes a near miss beside one,
    // and sometimes anywhere at all.
    function automatic t_addr pick_address();
        case ($urandom_range(9))
            0, 1:    return TICK_REG_ADDR;
            2:       return KEY_DATA_ADDR;
            3:       return KEY_STAT_ADDR;
            4, 5:    return CONSOLE_ADDR;
            6:       return CONTROL_ADDR;
            7:       return KEY_STAT_ADDR + 32'd4;
            8:       return CONSOLE_ADDR - 32'd4;
            default: return t_addr'($urandom);
        endcase
    endfunction

    // One random stretch of traffic. Runs of keys and runs of data reads push
    // the FIFO to full and back to empty; the rest exercises the timer, the
    // console, the control register and the decoder's unknown addresses.
    task automatic add_random_stretch();
        int unsigned run;
        int unsigned k;
        t_data       word;
        case ($urandom_range(9))
            0, 1, 2: begin
                run = ($urandom_range(7) == 0) ? $urandom_range(300, 240) : $urandom_range(20, 1);
                for (k = 0; k < run; k++)
                    add_beat(MODE_KEY, t_addr'($urandom), t_data'($urandom),
                             t_key'($urandom_range(255)));
            end
            3, 4, 5: begin
                run = ($urandom_range(5) == 0) ? $urandom_range(300, 200) : $urandom_range(20, 1);
                for (k = 0; k < run; k++)
                    add_beat(MODE_BUS_READ,
                             ($urandom_range(3) == 0) ? KEY_STAT_ADDR : KEY_DATA_ADDR,
                             t_data'($urandom), t_key'($urandom_range(255)));
            end
            6: begin
                // Ticks, sometimes after loading the timer just short of its
                // top so that it can wrap, with a read to see where it landed.
                if ($urandom_range(1) == 0)
                    add_beat(MODE_BUS_WRITE, TICK_REG_ADDR, 32'hFFFF_FFFF - $urandom_range(6),
                             t_key'($urandom_range(255)));
                run = $urandom_range(12, 1);
                for (k = 0; k < run; k++)
                    add_beat(MODE_TICK, t_addr'($urandom), t_data'($urandom),
                             t_key'($urandom_range(255)));
                add_beat(MODE_BUS_READ, TICK_REG_ADDR, t_data'($urandom),
                         t_key'($urandom_range(255)));
            end
            7, 8: begin
                run = $urandom_range(6, 1);
                for (k = 0; k < run; k++) begin
                    word = ($urandom_range(2) == 0) ? '0 : t_data'($urandom);
                    add_beat(($urandom_range(1) == 0) ? MODE_BUS_READ : MODE_BUS_WRITE,
                             pick_address(), word, t_key'($urandom_range(255)));
                end
            end
            default: begin
                // Pure noise over every field.
                add_beat(t_mode'($urandom_range(3)), t_addr'($urandom), t_data'($urandom),
                         t_key'($urandom_range(255)));
            end
        endcase
    endtask

    // The edge cases come first: empty reads, the four corners of a key byte
    // and their sign extension, a timer wrap, console and control writes,
    // writes to the read-only key registers and unknown addresses.
    task automatic add_directed_beats();
        add_beat(MODE_BUS_READ,  KEY_STAT_ADDR, '0, '0);
        add_beat(MODE_BUS_READ,  KEY_DATA_ADDR, '0, '0);
        add_beat(MODE_BUS_READ,  TICK_REG_ADDR, '1, '1);
        add_beat(MODE_KEY,       '1,            '1, 8'h00);
        add_beat(MODE_KEY,       '0,            '0, 8'hFF);
        add_beat(MODE_KEY,       '0,            '0, 8'h7F);
        add_beat(MODE_KEY,       '0,            '0, 8'h80);
        add_beat(MODE_BUS_READ,  KEY_STAT_ADDR, '0, '0);
        add_beat(MODE_BUS_WRITE, KEY_DATA_ADDR, '1, '0);
        add_beat(MODE_BUS_WRITE, KEY_STAT_ADDR, '0, '0);
        repeat (4) add_beat(MODE_BUS_READ, KEY_DATA_ADDR, '0, '0);
        add_beat(MODE_BUS_READ,  KEY_STAT_ADDR, '0, '0);
        add_beat(MODE_TICK,      '1,            '1, '1);
        add_beat(MODE_BUS_WRITE, TICK_REG_ADDR, '1, '0);
        add_beat(MODE_TICK,      '0,            '0, '0);
        add_beat(MODE_BUS_READ,  TICK_REG_ADDR, '0, '0);
        add_beat(MODE_BUS_WRITE, CONSOLE_ADDR,  32'hFFFF_FFA5, '0);
        add_beat(MODE_BUS_WRITE, CONSOLE_ADDR,  '0, '0);
        add_beat(MODE_BUS_WRITE, CONTROL_ADDR,  '0, '0);
        add_beat(MODE_BUS_WRITE, CONTROL_ADDR,  32'h8000_0000, '0);
        add_beat(MODE_BUS_READ,  CONSOLE_ADDR,  '0, '0);
        add_beat(MODE_BUS_READ,  '1,            '0, '0);
        add_beat(MODE_BUS_WRITE, '0,            '1, '0);
    endtask

    // Stimulus and end of run. Four phases of roughly equal length: the first
    // without idling, then a mostly idle sender, then no idling again (the
    // receiver side has no stall to apply), then a lightly idle sender.
    initial begin
        int unsigned gap_by_phase [4];
        int unsigned phase;
        int unsigned settle;
        gap_by_phase = '{0, 87, 0, 20};
        for (phase = 0; phase < 4; phase++) begin
            phase_gap = gap_by_phase[phase];
            if (phase == 0)
                add_directed_beats();
            while (pending_q.size() < BEAT_TARGET * (phase + 1) / 4)
                add_random_stretch();
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every beat to be taken, then give the last results a
        // bounded time to come back, then go on watching for stray strobes.
        while (pending_q.size() != 0 || start)
            @(posedge i_clk);
        settle = 0;
        while (expected_q.size() != 0 && settle < SETTLE_LIMIT) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (4) @(posedge i_clk);
        while (expected_q.size() != 0) begin
            void'(expected_q.pop_front());
            report_fault("expected result never arrived");
        end

        $display("Run covered %0d beats and %0d results; FIFO peaked at %0d keys, %0d popped,",
                 beats_taken, results_seen, peak_fill, keys_popped);
        $display("%0d dropped when full, %0d empty reads, %0d timer wraps, %0d console, %0d halts.",
                 keys_dropped, empty_reads, timer_wraps, console_bytes, halts_seen);
        if (fault_count == 0) begin
            $display("** mmio_keyboard_fifo_console_device: PASSED **");
        end else begin
            $display("%0d mismatches in total.", fault_count);
            $display("** mmio_keyboard_fifo_console_device: FAILED **");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("Timed out with %0d beats waiting and %0d results outstanding.",
                 pending_q.size(), expected_q.size());
        $display("** mmio_keyboard_fifo_console_device: FAILED **");
        $finish;
    end

endmodule
